// ----- rtl/arcsd_pkg.sv -----
// Shared types, constants and the arctangent table for the arc steering block.
package arcsd_pkg;

  localparam int CORDIC_STEPS_DEFAULT = 16;
  localparam int SEQ_CNT_W = 6;

  localparam int SQRT_ITERS = 32;
  localparam int RAD_DIV_ITERS = 51;
  localparam int VEL_DIV_ITERS = 41;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [30:0] R_MAX = 31'sd1073741823;

  localparam logic [2:0] REG_TARGET_X = 3'd0;
  localparam logic [2:0] REG_TARGET_Y = 3'd1;
  localparam logic [2:0] REG_DRIVE_SPEED = 3'd2;
  localparam logic [2:0] REG_ARRIVE_TOL = 3'd3;
  localparam logic [2:0] REG_HALF_TRACK = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WRAP,
    S_CORDIC,
    S_LAT0,
    S_LAT1,
    S_DSQ0,
    S_DSQ1,
    S_SQD_SET,
    S_SQ_DIST,
    S_DIV_RAD,
    S_TERMS,
    S_MAG0,
    S_MAG1,
    S_SQM_SET,
    S_SQ_MAG,
    S_KL,
    S_LSET,
    S_DIV_LEFT,
    S_KR,
    S_RSET,
    S_DIV_RIGHT,
    S_DONE
  } state_t;

  function automatic logic [28:0] atan_q16(input logic [4:0] idx);
    logic [28:0] v;
    case (idx)
      5'd0: v = 29'd294912000;
      5'd1: v = 29'd174096719;
      5'd2: v = 29'd91987925;
      5'd3: v = 29'd46694507;
      5'd4: v = 29'd23437865;
      5'd5: v = 29'd11730455;
      5'd6: v = 29'd5866610;
      5'd7: v = 29'd2933484;
      5'd8: v = 29'd1466766;
      5'd9: v = 29'd733385;
      5'd10: v = 29'd366693;
      5'd11: v = 29'd183347;
      5'd12: v = 29'd91674;
      5'd13: v = 29'd45837;
      5'd14: v = 29'd22918;
      5'd15: v = 29'd11459;
      5'd16: v = 29'd5730;
      5'd17: v = 29'd2865;
      5'd18: v = 29'd1432;
      5'd19: v = 29'd716;
      5'd20: v = 29'd358;
      5'd21: v = 29'd179;
      5'd22: v = 29'd90;
      5'd23: v = 29'd45;
      5'd24: v = 29'd22;
      5'd25: v = 29'd11;
      5'd26: v = 29'd6;
      5'd27: v = 29'd3;
      5'd28: v = 29'd1;
      5'd29: v = 29'd1;
      default: v = 29'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/arc_steer_diff_drive.sv -----
// Top level of the arc steering differential drive controller.
// One pose transaction runs heading wrap, CORDIC_STEPS CORDIC iterations, up to eight
// products on the shared multiplier, two 32-step square roots and up to three restoring
// divisions (51, 41 and 41 steps) on the one shared compare/subtract unit. An item that
// meets the arrival tolerance, or any item once the finished flag is set, goes from idle
// straight to done. in_stall is high in every state but idle; a loaded result waits in
// the output register while the next pose is taken. Only reset clears finished.
module arc_steer_diff_drive #(
  parameter int CORDIC_STEPS = arcsd_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [12:0] pos_x,
  input  logic signed [12:0] pos_y,
  input  logic signed [16:0] yaw_centideg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [10:0] left_velocity,
  output logic signed [10:0] right_velocity,
  output logic               arrived
);

  localparam int CW = arcsd_pkg::SEQ_CNT_W;

  arcsd_pkg::state_t state, state_next;

  logic signed [12:0] target_x;
  logic signed [12:0] target_y;
  logic [6:0]         drive_speed;
  logic [9:0]         arrive_tolerance;
  logic [8:0]         half_track;
  logic               finished;

  logic signed [13:0] dx, dy;
  logic signed [17:0] ang;
  logic               neg;
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic [CW-1:0]      cnt;
  logic signed [69:0] acc;
  logic signed [47:0] lat;
  logic signed [30:0] rad;
  logic signed [32:0] lt, rt;
  logic [32:0]        mag;
  logic               pneg;
  logic [63:0]        num, den, quo;
  logic [65:0]        rem;
  logic signed [10:0] lv, rv;
  logic               arr;

  logic               accept, out_load;
  logic signed [13:0] in_dx, in_dy;
  logic [13:0]        adx, ady;
  logic               near;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != arcsd_pkg::S_IDLE);
  assign out_load = (state == arcsd_pkg::S_DONE) && (!out_valid || !out_stall);

  assign in_dx = 14'(target_x) - 14'(pos_x);
  assign in_dy = 14'(target_y) - 14'(pos_y);
  assign adx = in_dx[13] ? 14'(-in_dx) : 14'(in_dx);
  assign ady = in_dy[13] ? 14'(-in_dy) : 14'(in_dy);
  assign near = (adx <= 14'(arrive_tolerance)) || (ady <= 14'(arrive_tolerance));

  // heading wrap and fold
  logic signed [17:0] a_wrap, a_fold;
  logic               fold_neg;
  always_comb begin
    a_wrap = (ang > 18'sd18000) ? ang - 18'sd36000 : ang;
    a_fold = a_wrap;
    fold_neg = 1'b0;
    if (a_wrap > 18'sd9000) begin
      a_fold = a_wrap - 18'sd18000;
      fold_neg = 1'b1;
    end else if (a_wrap < -18'sd9000) begin
      a_fold = a_wrap + 18'sd18000;
      fold_neg = 1'b1;
    end
  end

  // CORDIC rotation step
  logic signed [33:0] xs, ys, cx_step, cy_step;
  logic signed [32:0] cz_step, atan_v;
  always_comb begin
    xs = cx >>> cnt[4:0];
    ys = cy >>> cnt[4:0];
    atan_v = $signed({4'b0, arcsd_pkg::atan_q16(cnt[4:0])});
    if (!cz[32]) begin
      cx_step = cx - ys;
      cy_step = cy + xs;
      cz_step = cz - atan_v;
    end else begin
      cx_step = cx + ys;
      cy_step = cy - xs;
      cz_step = cz + atan_v;
    end
  end

  // shared multiplier
  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      arcsd_pkg::S_LAT0: begin mul_a = 35'(dx); mul_b = 35'(cx); end
      arcsd_pkg::S_LAT1: begin mul_a = 35'(dy); mul_b = 35'(cy); end
      arcsd_pkg::S_DSQ0: begin mul_a = 35'(dx); mul_b = 35'(dx); end
      arcsd_pkg::S_DSQ1: begin mul_a = 35'(dy); mul_b = 35'(dy); end
      arcsd_pkg::S_MAG0: begin mul_a = 35'(lt); mul_b = 35'(lt); end
      arcsd_pkg::S_MAG1: begin mul_a = 35'(rt); mul_b = 35'(rt); end
      arcsd_pkg::S_KL: begin
        mul_a = 35'(lt);
        mul_b = $signed({26'b0, drive_speed, 2'b0} + {27'b0, drive_speed, 1'b0});
      end
      arcsd_pkg::S_KR: begin
        mul_a = 35'(rt);
        mul_b = $signed({26'b0, drive_speed, 2'b0} + {27'b0, drive_speed, 1'b0});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod = mul_a * mul_b;
  end

  // shared compare/subtract unit: square root and division steps
  logic        op_sqrt;
  logic [65:0] cmp_a, cmp_b;
  logic [66:0] diff;
  logic        ge;
  logic [65:0] rem_step;
  logic [63:0] quo_step, num_step;
  always_comb begin
    op_sqrt = (state == arcsd_pkg::S_SQ_DIST) || (state == arcsd_pkg::S_SQ_MAG);
    cmp_a = op_sqrt ? {rem[63:0], num[63:62]} : {rem[64:0], num[63]};
    cmp_b = op_sqrt ? {quo, 2'b01} : {2'b00, den};
    diff = {1'b0, cmp_a} - {1'b0, cmp_b};
    ge = !diff[66];
    rem_step = ge ? diff[65:0] : cmp_a;
    quo_step = {quo[62:0], ge};
    num_step = op_sqrt ? {num[61:0], 2'b00} : {num[62:0], 1'b0};
  end

  logic [63:0]        lat_abs;
  logic [69:0]        p_abs;
  logic signed [30:0] rad_q;
  logic signed [32:0] ht_q8, lt_raw, rt_raw;
  always_comb begin
    lat_abs = lat[47] ? 64'(-lat) : 64'(lat);
    p_abs = acc[69] ? 70'(-acc) : 70'(acc);
    rad_q = (quo_step > 64'(arcsd_pkg::R_MAX)) ? arcsd_pkg::R_MAX : $signed(quo_step[30:0]);
    ht_q8 = $signed({16'b0, half_track, 8'b0});
    lt_raw = 33'(rad) - ht_q8;
    rt_raw = 33'(rad) + ht_q8;
  end

  always_comb begin
    state_next = state;
    case (state)
      arcsd_pkg::S_IDLE:
        if (accept) state_next = (near || finished) ? arcsd_pkg::S_DONE : arcsd_pkg::S_WRAP;
      arcsd_pkg::S_WRAP:
        if (!ang[17] && ang < 18'sd36000) state_next = arcsd_pkg::S_CORDIC;
      arcsd_pkg::S_CORDIC:
        if (cnt == CW'(CORDIC_STEPS - 1)) state_next = arcsd_pkg::S_LAT0;
      arcsd_pkg::S_LAT0: state_next = arcsd_pkg::S_LAT1;
      arcsd_pkg::S_LAT1: state_next = arcsd_pkg::S_DSQ0;
      arcsd_pkg::S_DSQ0: state_next = arcsd_pkg::S_DSQ1;
      arcsd_pkg::S_DSQ1: state_next = arcsd_pkg::S_SQD_SET;
      arcsd_pkg::S_SQD_SET: state_next = arcsd_pkg::S_SQ_DIST;
      arcsd_pkg::S_SQ_DIST:
        if (cnt == CW'(arcsd_pkg::SQRT_ITERS - 1))
          state_next = (lat == '0) ? arcsd_pkg::S_TERMS : arcsd_pkg::S_DIV_RAD;
      arcsd_pkg::S_DIV_RAD:
        if (cnt == CW'(arcsd_pkg::RAD_DIV_ITERS - 1)) state_next = arcsd_pkg::S_TERMS;
      arcsd_pkg::S_TERMS: state_next = arcsd_pkg::S_MAG0;
      arcsd_pkg::S_MAG0: state_next = arcsd_pkg::S_MAG1;
      arcsd_pkg::S_MAG1: state_next = arcsd_pkg::S_SQM_SET;
      arcsd_pkg::S_SQM_SET: state_next = arcsd_pkg::S_SQ_MAG;
      arcsd_pkg::S_SQ_MAG:
        if (cnt == CW'(arcsd_pkg::SQRT_ITERS - 1))
          state_next = (quo_step == '0) ? arcsd_pkg::S_DONE : arcsd_pkg::S_KL;
      arcsd_pkg::S_KL: state_next = arcsd_pkg::S_LSET;
      arcsd_pkg::S_LSET: state_next = arcsd_pkg::S_DIV_LEFT;
      arcsd_pkg::S_DIV_LEFT:
        if (cnt == CW'(arcsd_pkg::VEL_DIV_ITERS - 1)) state_next = arcsd_pkg::S_KR;
      arcsd_pkg::S_KR: state_next = arcsd_pkg::S_RSET;
      arcsd_pkg::S_RSET: state_next = arcsd_pkg::S_DIV_RIGHT;
      arcsd_pkg::S_DIV_RIGHT:
        if (cnt == CW'(arcsd_pkg::VEL_DIV_ITERS - 1)) state_next = arcsd_pkg::S_DONE;
      arcsd_pkg::S_DONE:
        if (out_load) state_next = arcsd_pkg::S_IDLE;
      default: state_next = arcsd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arcsd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
      drive_speed <= 7'd50;
      arrive_tolerance <= 10'd50;
      half_track <= 9'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        arcsd_pkg::REG_TARGET_X: target_x <= $signed(cfg_data);
        arcsd_pkg::REG_TARGET_Y: target_y <= $signed(cfg_data);
        arcsd_pkg::REG_DRIVE_SPEED: drive_speed <= cfg_data[6:0];
        arcsd_pkg::REG_ARRIVE_TOL: arrive_tolerance <= cfg_data[9:0];
        arcsd_pkg::REG_HALF_TRACK: half_track <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finished <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept && near) finished <= 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_velocity <= lv;
      right_velocity <= rv;
      arrived <= arr;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      arcsd_pkg::S_IDLE: begin
        dx <= in_dx;
        dy <= in_dy;
        ang <= 18'(yaw_centideg) + 18'sd9000;
        arr <= near || finished;
        lv <= '0;
        rv <= '0;
      end
      arcsd_pkg::S_WRAP: begin
        if (ang[17]) begin
          ang <= ang + 18'sd36000;
        end else if (ang >= 18'sd36000) begin
          ang <= ang - 18'sd36000;
        end else begin
          neg <= fold_neg;
          cz <= $signed({17'(a_fold), 16'b0});
          cx <= arcsd_pkg::CORDIC_GAIN_Q30;
          cy <= '0;
          cnt <= '0;
        end
      end
      arcsd_pkg::S_CORDIC: begin
        cnt <= cnt + 1'b1;
        cz <= cz_step;
        if (cnt == CW'(CORDIC_STEPS - 1) && neg) begin
          cx <= -cx_step;
          cy <= -cy_step;
        end else begin
          cx <= cx_step;
          cy <= cy_step;
        end
      end
      arcsd_pkg::S_LAT0, arcsd_pkg::S_MAG0, arcsd_pkg::S_KL, arcsd_pkg::S_KR: acc <= prod;
      arcsd_pkg::S_LAT1, arcsd_pkg::S_DSQ1, arcsd_pkg::S_MAG1: acc <= acc + prod;
      arcsd_pkg::S_DSQ0: begin
        lat <= acc[47:0];
        acc <= prod;
      end
      arcsd_pkg::S_SQD_SET, arcsd_pkg::S_SQM_SET: begin
        num <= (state == arcsd_pkg::S_SQD_SET) ? {acc[31:0], 32'b0} : acc[63:0];
        rem <= '0;
        quo <= '0;
        cnt <= '0;
      end
      arcsd_pkg::S_SQ_DIST: begin
        if (cnt == CW'(arcsd_pkg::SQRT_ITERS - 1)) begin
          num <= {quo_step[29:0], 34'b0};
          den <= lat_abs;
          rem <= '0;
          quo <= '0;
          cnt <= '0;
          rad <= arcsd_pkg::R_MAX;
        end else begin
          cnt <= cnt + 1'b1;
          rem <= rem_step;
          quo <= quo_step;
          num <= num_step;
        end
      end
      arcsd_pkg::S_DIV_RAD: begin
        cnt <= cnt + 1'b1;
        rem <= rem_step;
        quo <= quo_step;
        num <= num_step;
        if (cnt == CW'(arcsd_pkg::RAD_DIV_ITERS - 1)) rad <= lat[47] ? -rad_q : rad_q;
      end
      arcsd_pkg::S_TERMS: begin
        lt <= (rad <= 31'sd0) ? -lt_raw : lt_raw;
        rt <= (rad <= 31'sd0) ? -rt_raw : rt_raw;
      end
      arcsd_pkg::S_SQ_MAG: begin
        cnt <= cnt + 1'b1;
        rem <= rem_step;
        quo <= quo_step;
        num <= num_step;
        if (cnt == CW'(arcsd_pkg::SQRT_ITERS - 1)) mag <= quo_step[32:0];
      end
      arcsd_pkg::S_LSET, arcsd_pkg::S_RSET: begin
        num <= {p_abs[40:0], 23'b0};
        den <= 64'(mag);
        pneg <= acc[69];
        rem <= '0;
        quo <= '0;
        cnt <= '0;
      end
      arcsd_pkg::S_DIV_LEFT, arcsd_pkg::S_DIV_RIGHT: begin
        cnt <= cnt + 1'b1;
        rem <= rem_step;
        quo <= quo_step;
        num <= num_step;
        if (cnt == CW'(arcsd_pkg::VEL_DIV_ITERS - 1)) begin
          if (state == arcsd_pkg::S_DIV_LEFT) begin
            lv <= pneg ? $signed(quo_step[10:0]) : -$signed(quo_step[10:0]);
          end else begin
            rv <= pneg ? -$signed(quo_step[10:0]) : $signed(quo_step[10:0]);
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_arrived_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && arrived |-> left_velocity == '0 && right_velocity == '0)
    else $error("arrived result carries nonzero velocity");

  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("finished cleared without reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != arcsd_pkg::S_IDLE)
    else $error("accepted transaction did not start work");

  a_cordic_bound: assert property (@(posedge clk) disable iff (rst)
    state == arcsd_pkg::S_CORDIC |-> cnt < CW'(CORDIC_STEPS))
    else $error("CORDIC step count overrun");

  a_done_load: assert property (@(posedge clk) disable iff (rst)
    state == arcsd_pkg::S_DONE && !out_valid |=> out_valid)
    else $error("finished result not loaded into output register");
`endif

endmodule

// ----- dv/arc_steer_diff_drive_tb.sv -----
// Self-checking testbench for the arc steering differential drive controller.
`timescale 1ns / 1ps

module arc_steer_diff_drive_tb;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS = 290;

  typedef struct {
    int px;
    int py;
    int yaw;
  } pose_t;

  typedef struct {
    logic [10:0] lv;
    logic [10:0] rv;
    logic        arr;
  } wheel_cmd_t;

  localparam longint ATAN_Q16 [16] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730455,
    5866610, 2933484, 1466766, 733385, 366693, 183347, 91674, 45837,
    22918, 11459
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [12:0] pos_x = '0;
  logic signed [12:0] pos_y = '0;
  logic signed [16:0] yaw_centideg = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [10:0] left_velocity;
  logic signed [10:0] right_velocity;
  logic arrived;

  arc_steer_diff_drive dut (.*);

  always #5 clk = ~clk;

  longint tgt_x = 0, tgt_y = 0, speed = 50, tol = 50, half_trk = 50;
  bit arrived_latch = 0;
  pose_t pose_q[$];
  wheel_cmd_t expected_cmds[$];
  int errors = 0;
  bit idle_en = 1;
  bit long_hold_req = 0;
  int in_gap = 0, out_gap = 0, hold_cnt = 0, quiet_cycles = 0;

  function automatic longint unsigned root_u64(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic wheel_cmd_t steer_predict(pose_t p);
    longint dx, dy, a, z, x, y, xs, ys, lat, r, lt, rt, k, lv, rv;
    longint unsigned dist_q16, mag, q;
    bit neg;
    wheel_cmd_t c;
    dx = tgt_x - p.px;
    dy = tgt_y - p.py;
    neg = 0;
    if (mag64(dx) <= tol || mag64(dy) <= tol) arrived_latch = 1;
    if (arrived_latch) begin
      c.lv = '0;
      c.rv = '0;
      c.arr = 1'b1;
      return c;
    end
    a = (longint'(p.yaw) + 9000) % 36000;
    if (a < 0) a += 36000;
    if (a > 18000) a -= 36000;
    if (a > 9000) begin
      a -= 18000;
      neg = 1;
    end else if (a < -9000) begin
      a += 18000;
      neg = 1;
    end
    z = a * 65536;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= ATAN_Q16[i];
      end else begin
        x += ys;
        y -= xs;
        z += ATAN_Q16[i];
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    lat = dx * x + dy * y;
    dist_q16 = root_u64(longint'(dx * dx + dy * dy) << 32);
    if (lat == 0) begin
      r = arcsd_pkg::R_MAX;
    end else begin
      q = (dist_q16 << 21) / longint'(mag64(lat));
      if (q > 64'd1073741823) q = 64'd1073741823;
      r = lat < 0 ? -longint'(q) : longint'(q);
    end
    lt = r - (half_trk << 8);
    rt = r + (half_trk << 8);
    if (r <= 0) begin
      lt = -lt;
      rt = -rt;
    end
    mag = root_u64(longint'(lt * lt) + longint'(rt * rt));
    k = speed * 6;
    if (mag == 0) begin
      lv = 0;
      rv = 0;
    end else begin
      lv = -((lt * k) / longint'(mag));
      rv = (rt * k) / longint'(mag);
    end
    c.lv = lv[10:0];
    c.rv = rv[10:0];
    c.arr = 1'b0;
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        expected_cmds.insert(expected_cmds.size(),
                             steer_predict('{int'(pos_x), int'(pos_y), int'(yaw_centideg)}));
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (pose_q.size() > 0) begin
        pose_t p;
        p = pose_q.pop_front();
        pos_x <= p.px;
        pos_y <= p.py;
        yaw_centideg <= p.yaw;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        wheel_cmd_t e;
        e = expected_cmds.pop_front();
        if (left_velocity !== e.lv)
          report_mismatch("left_velocity", left_velocity, $signed(e.lv));
        if (right_velocity !== e.rv)
          report_mismatch("right_velocity", right_velocity, $signed(e.rv));
        if (arrived !== e.arr) report_mismatch("arrived", arrived, e.arr);
      end
    end
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[12:0];
    case (idx)
      arcsd_pkg::REG_TARGET_X: tgt_x = longint'($signed(val[12:0]));
      arcsd_pkg::REG_TARGET_Y: tgt_y = longint'($signed(val[12:0]));
      arcsd_pkg::REG_DRIVE_SPEED: speed = val[6:0];
      arcsd_pkg::REG_ARRIVE_TOL: tol = val[9:0];
      arcsd_pkg::REG_HALF_TRACK: half_trk = val[8:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int tx, int ty, int spd, int tl, int ht);
    write_reg(arcsd_pkg::REG_TARGET_X, tx);
    write_reg(arcsd_pkg::REG_TARGET_Y, ty);
    write_reg(arcsd_pkg::REG_DRIVE_SPEED, spd);
    write_reg(arcsd_pkg::REG_ARRIVE_TOL, tl);
    write_reg(arcsd_pkg::REG_HALF_TRACK, ht);
  endtask

  task automatic drain();
    while (pose_q.size() > 0 || in_valid || expected_cmds.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_pose(int px, int py, int yaw);
    pose_t p;
    p.px = px;
    p.py = py;
    p.yaw = yaw;
    pose_q.insert(pose_q.size(), p);
  endtask

  task automatic push_random(int n);
    int px, py, yaw;
    for (int i = 0; i < n; i++) begin
      do begin
        px = int'($urandom_range(0, 8191)) - 4096;
        py = int'($urandom_range(0, 8191)) - 4096;
      end while (mag64(tgt_x - px) <= tol || mag64(tgt_y - py) <= tol);
      if ($urandom_range(0, 7) == 0)
        yaw = int'($urandom_range(0, 131071)) - 65536;
      else
        yaw = int'($urandom_range(0, 54000)) - 18000;
      push_pose(px, py, yaw);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, reset configuration
    push_pose(-4096, -4096, -18000);
    push_pose(4095, 4095, 36000);
    push_pose(4095, -4096, 0);
    push_pose(-4096, 4095, 9000);
    push_pose(1000, 200, -9000);
    push_pose(-300, 2000, 27000);
    push_pose(2000, 2000, 18000);
    push_pose(-2000, 100, 65535);
    push_pose(100, -2000, -65536);
    push_pose(-51, 4095, 4500);
    drain();

    // out-of-range indexes are ignored
    write_reg(3'd5, 13'h1fff);
    write_reg(3'd7, 13'h0aaa);
    set_config(-4096, 4095, 127, 0, 511);
    push_pose(4095, -4096, 13500);
    push_pose(-4095, 4094, 0);
    push_pose(0, 0, 31000);
    push_pose(-4095, 0, -12345);
    push_random(PHASE_ITEMS);
    drain();

    set_config(4095, -4096, 0, 1023, 0);
    push_pose(-4096, 4095, 0);
    push_random(PHASE_ITEMS);
    long_hold_req = 1;
    drain();

    set_config(1234, -777, 100, 7, 255);
    push_random(PHASE_ITEMS);
    drain();

    set_config(-2048, 2047, 1, 300, 1);
    push_random(PHASE_ITEMS);
    drain();

    set_config(0, 0, 63, 50, 128);
    push_random(PHASE_ITEMS);
    drain();

    idle_en = 0;
    set_config(300, -300, 100, 20, 100);
    push_random(PHASE_ITEMS);
    // arrival on one axis, then every later sample stays arrived
    push_pose(310, 4000, 1000);
    push_pose(-4000, -4000, 2000);
    push_pose(4095, 4095, -18000);
    push_random(5);
    drain();

    if (expected_cmds.size() != 0) report_mismatch("results left over", 0, 0);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
